>>> rtl/vsa_pkg.sv
// Shared types and constants for the validated sample averager.
// No dependencies; imported by every module of the block.
package vsa_pkg;

  localparam int SampleW  = 18;
  localparam int SumW     = 22;
  localparam int AttW     = 4;
  localparam int LimitW   = 18;
  localparam int PaddrW   = 4;
  localparam int PdataW   = 32;

  localparam int VSA_SAMPLES_DEF = 4;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_SPREAD_LIMIT   = 2'd0;
  localparam logic [1:0] REG_MAX_ATTEMPTS   = 2'd1;
  localparam logic [1:0] REG_FALLBACK_VALUE = 2'd2;

  localparam logic [LimitW-1:0]         SPREAD_LIMIT_RST   = LimitW'(5000);
  localparam logic [AttW-1:0]           MAX_ATTEMPTS_RST   = AttW'(3);
  localparam logic signed [SampleW-1:0] FALLBACK_VALUE_RST = SampleW'(25000);

  localparam logic signed [SampleW-1:0] SAMPLE_MAX = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SAMPLE_MIN = {1'b1, {(SampleW-1){1'b0}}};

  typedef struct packed {
    logic [LimitW-1:0]         spread_limit;
    logic [AttW-1:0]           max_attempts;
    logic signed [SampleW-1:0] fallback_value;
  } vsa_cfg_t;

  // one finished measurement, before the average is worked out
  typedef struct packed {
    logic                      is_avg;
    logic signed [SumW-1:0]    sum;
    logic signed [SampleW-1:0] fallback;
    logic [AttW-1:0]           used;
  } vsa_rec_t;

endpackage

>>> rtl/vsa_apb.sv
// APB-style configuration registers of the sample averager.
// Depends on vsa_pkg.
module vsa_apb import vsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output vsa_cfg_t          cfg_o
);

  vsa_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spread_limit   <= SPREAD_LIMIT_RST;
      cfg_q.max_attempts   <= MAX_ATTEMPTS_RST;
      cfg_q.fallback_value <= FALLBACK_VALUE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SPREAD_LIMIT:   cfg_q.spread_limit   <= pwdata[LimitW-1:0];
        REG_MAX_ATTEMPTS:   cfg_q.max_attempts   <= pwdata[AttW-1:0];
        REG_FALLBACK_VALUE: cfg_q.fallback_value <= pwdata[SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPREAD_LIMIT:   prdata = PdataW'(cfg_q.spread_limit);
      REG_MAX_ATTEMPTS:   prdata = PdataW'(cfg_q.max_attempts);
      REG_FALLBACK_VALUE: prdata = PdataW'(signed'(cfg_q.fallback_value));
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/vsa_stats.sv
// Input register, round statistics (min, max, sum, counters) and the
// per-item decision; emits a record register. Depends on vsa_pkg.
module vsa_stats import vsa_pkg::*; #(
  parameter int SAMPLES = VSA_SAMPLES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      read_ok_i,
  input  vsa_cfg_t                  cfg_i,
  output logic                      rec_valid_o,
  output vsa_rec_t                  rec_o,
  input  logic                      rec_stall_i
);

  localparam int IdxW = $clog2(SAMPLES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SAMPLES - 1);

  // input register
  logic                      in_valid_q;
  logic signed [SampleW-1:0] sample_q;
  logic                      read_ok_q;

  // round state
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [AttW-1:0]           att_q, att_d;
  logic signed [SampleW-1:0] min_q, min_d, max_q, max_d;
  logic signed [SumW-1:0]    sum_q, sum_d;

  // record register
  logic     rec_valid_q;
  vsa_rec_t rec_q, rec_d;

  logic rec_ready, consume, accept, has_res;

  logic signed [SampleW-1:0] new_min, new_max;
  logic signed [SumW-1:0]    new_sum;
  logic [SampleW:0]          spread;
  logic                      spread_bad;
  logic [AttW-1:0]           limit_eff, used;
  logic                      reject, clear;

  assign rec_ready  = !rec_valid_q || !rec_stall_i;
  assign consume    = in_valid_q && rec_ready;
  assign in_stall_o = in_valid_q && !rec_ready;
  assign accept     = in_valid_i && !in_stall_o;

  assign new_min    = (sample_q < min_q) ? sample_q : min_q;
  assign new_max    = (sample_q > max_q) ? sample_q : max_q;
  assign new_sum    = sum_q + SumW'(sample_q);
  // min <= max once a sample is in, so the spread is never negative
  assign spread     = {new_max[SampleW-1], new_max} - {new_min[SampleW-1], new_min};
  assign spread_bad = spread > {1'b0, cfg_i.spread_limit};
  assign limit_eff  = (cfg_i.max_attempts == '0) ? AttW'(1) : cfg_i.max_attempts;
  assign used       = att_q + AttW'(1);

  always_comb begin
    idx_d   = idx_q;
    att_d   = att_q;
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    reject  = 1'b0;
    clear   = 1'b0;
    has_res = 1'b0;
    rec_d.is_avg   = 1'b0;
    rec_d.sum      = new_sum;
    rec_d.fallback = cfg_i.fallback_value;
    rec_d.used     = used;

    if (!read_ok_q) begin
      reject = 1'b1;
    end else if (idx_q == LastIdx) begin
      if (spread_bad) begin
        reject = 1'b1;
      end else begin
        has_res      = 1'b1;
        rec_d.is_avg = 1'b1;
        att_d        = '0;
        clear        = 1'b1;
      end
    end else begin
      idx_d = idx_q + IdxW'(1);
      min_d = new_min;
      max_d = new_max;
      sum_d = new_sum;
    end

    if (reject) begin
      clear = 1'b1;
      if (used >= limit_eff) begin
        has_res = 1'b1;
        att_d   = '0;
      end else begin
        att_d = used;
      end
    end

    if (clear) begin
      idx_d = '0;
      min_d = SAMPLE_MAX;
      max_d = SAMPLE_MIN;
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rec_valid_q <= 1'b0;
      idx_q       <= '0;
      att_q       <= '0;
      min_q       <= SAMPLE_MAX;
      max_q       <= SAMPLE_MIN;
      sum_q       <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        rec_valid_q <= has_res;
        idx_q       <= idx_d;
        att_q       <= att_d;
        min_q       <= min_d;
        max_q       <= max_d;
        sum_q       <= sum_d;
      end else if (rec_ready) begin
        rec_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q  <= sample_i;
      read_ok_q <= read_ok_i;
    end
    if (consume && has_res) begin
      rec_q <= rec_d;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

>>> rtl/vsa_div.sv
// Round average by reciprocal multiply (truncated toward zero) plus the
// output register. Depends on vsa_pkg.
module vsa_div import vsa_pkg::*; #(
  parameter int SAMPLES = VSA_SAMPLES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rec_valid_i,
  input  vsa_rec_t                  rec_i,
  output logic                      rec_stall_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] result_temp_o,
  output logic                      result_valid_o,
  output logic [AttW-1:0]           attempts_used_o
);

  // |sum| <= 2^21 < 2^SumW; with the shift below the product is exact
  // for every magnitude, power-of-two SAMPLES included.
  localparam int Shift   = SumW + $clog2(SAMPLES);
  localparam int RecipW  = Shift;
  localparam logic [RecipW-1:0] Recip = RecipW'(((1 << Shift) + SAMPLES - 1) / SAMPLES);
  localparam int QuotW   = SumW - 1;
  localparam int ProdW   = SumW + RecipW;

  // stage 2: quotient magnitude
  logic                      v2_q;
  logic                      is_avg_q, neg_q;
  logic [QuotW-1:0]          quot_q;
  logic signed [SampleW-1:0] fb_q;
  logic [AttW-1:0]           used_q;

  // output register
  logic                      out_valid_q;
  logic signed [SampleW-1:0] temp_q;
  logic                      tvalid_q;
  logic [AttW-1:0]           att_q;

  logic              out_ready, s2_ready, load2, load_out, neg;
  logic [SumW-1:0]   mag;
  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot;
  logic [SampleW-1:0] avg;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign s2_ready    = !v2_q || out_ready;
  assign rec_stall_o = !s2_ready;
  assign load2       = rec_valid_i && s2_ready;
  assign load_out    = v2_q && out_ready;

  assign neg  = rec_i.sum[SumW-1];
  assign mag  = neg ? SumW'(-rec_i.sum) : SumW'(rec_i.sum);
  assign prod = ProdW'(mag) * ProdW'(Recip);
  assign quot = prod[Shift +: QuotW];

  // the average always fits the sample range
  assign avg = neg_q ? SampleW'(-quot_q) : SampleW'(quot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load2) begin
        v2_q <= 1'b1;
      end else if (out_ready) begin
        v2_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      is_avg_q <= rec_i.is_avg;
      neg_q    <= neg;
      quot_q   <= quot;
      fb_q     <= rec_i.fallback;
      used_q   <= rec_i.used;
    end
    if (load_out) begin
      temp_q   <= is_avg_q ? avg : fb_q;
      tvalid_q <= is_avg_q;
      att_q    <= used_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_temp_o   = temp_q;
  assign result_valid_o  = tvalid_q;
  assign attempts_used_o = att_q;

endmodule

>>> rtl/validated_sample_averager.sv
// Validated sample averager: top level.
// Depends on vsa_pkg, vsa_apb, vsa_stats and vsa_div.
//
// Usage:
//  - Input channel: one beat carries one reading (sample_i, millidegrees,
//    two's complement) and read_ok_i. A beat is taken when in_valid_i is
//    high and in_stall_o is low.
//  - Every SAMPLES good readings close a round. A failed read or a round
//    whose max - min exceeds spread_limit burns one attempt; after
//    max_attempts rejected rounds the fallback value goes out with
//    result_valid_o low. An accepted round gives sum / SAMPLES, rounded
//    toward zero, with result_valid_o high.
//  - Output channel: at most one beat per input beat, taken when
//    out_valid_o is high and out_stall_i is low.
//  - Path: a result reaches out_valid_o through the input register, the
//    stats/decision register, the quotient register and the output
//    register.
//  - Throughput: one beat per cycle while out_stall_i is low; round state
//    gets one compare/add per beat, the average one constant multiply.
//  - Receiver stall: the pipeline registers fill up behind the stalled
//    output and in_stall_o rises only once the input register is blocked.
//  - Reset (rst_ni low, async): pipeline empty, round cleared, config back
//    to 5000 / 3 / 25000. No clearing pass; beats may follow at once.
//  - Config: APB, registers at 0x0, 0x4, 0x8; write only while idle.
module validated_sample_averager import vsa_pkg::*; #(
  parameter int SAMPLES = VSA_SAMPLES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      read_ok_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] result_temp_o,
  output logic                      result_valid_o,
  output logic [AttW-1:0]           attempts_used_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PaddrW-1:0]         paddr,
  input  logic [PdataW-1:0]         pwdata,
  output logic [PdataW-1:0]         prdata,
  output logic                      pready
);

  vsa_cfg_t cfg;
  vsa_rec_t rec;
  logic     rec_valid;
  logic     rec_stall;

  vsa_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // round bookkeeping and per-beat decision
  vsa_stats #(.SAMPLES(SAMPLES)) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .read_ok_i   (read_ok_i),
    .cfg_i       (cfg),
    .rec_valid_o (rec_valid),
    .rec_o       (rec),
    .rec_stall_i (rec_stall)
  );

  // average and output register
  vsa_div #(.SAMPLES(SAMPLES)) u_div (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (rec_valid),
    .rec_i           (rec),
    .rec_stall_o     (rec_stall),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_temp_o   (result_temp_o),
    .result_valid_o  (result_valid_o),
    .attempts_used_o (attempts_used_o)
  );

endmodule

>>> rtl/vsa_checker.sv
// Port-level checks for the validated sample averager, bound to the top.
// Depends on vsa_pkg and validated_sample_averager.
module vsa_checker import vsa_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [SampleW-1:0] result_temp_o,
  input logic                      result_valid_o,
  input logic [AttW-1:0]           attempts_used_o
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_temp_o) && $stable(result_valid_o)
      && $stable(attempts_used_o))
    else $error("output payload changed under stall");

  // stall only while a taken beat is still held
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(in_valid_i && !in_stall_o) || $past(in_stall_o))
    else $error("input stalled with nothing pending");

  // every result counts at least the round it came from
  a_att_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> attempts_used_o != '0)
    else $error("result with zero attempts");

endmodule

bind validated_sample_averager vsa_checker u_vsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_temp_o   (result_temp_o),
  .result_valid_o  (result_valid_o),
  .attempts_used_o (attempts_used_o)
);
